>>> sv/crsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsr_pkg
// Shared types and constants of the circle ring span rasterizer.
// ----------------------------------------------------------------------------
package crsr_pkg;

  localparam int XY_W    = 16;
  localparam int RAD_W   = 12;
  localparam int LEN_W   = 13;
  localparam int COLOR_W = 16;
  localparam int SPAN_W  = 16;
  localparam int ROW_W   = 15;  // column, rows and row deltas
  localparam int ERR_W   = 18;  // midpoint error terms
  localparam int QDEPTH  = 2;
  localparam int NSPAN_FILL = 4;
  localparam int NSPAN_RING = 8;
  localparam int IDX_W   = 3;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic {
    KIND_SPAN = 1'b0,
    KIND_IDLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FILL,
    MODE_RING
  } mode_e;

  typedef logic signed [ROW_W-1:0] row_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    op_e                operation;
    logic [XY_W-1:0]    center_x;
    logic [XY_W-1:0]    center_y;
    logic [RAD_W-1:0]   radius;
    logic [RAD_W-1:0]   thickness;
    logic [COLOR_W-1:0] paint_color;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [XY_W-1:0]    rect_x;
    logic [XY_W-1:0]    rect_y;
    logic [LEN_W-1:0]   rect_w;
    logic [LEN_W-1:0]   rect_h;
    logic [COLOR_W-1:0] rect_color;
    logic               last;
    logic               finished;
  } out_t;

  // one column step as handed from the front to the back
  typedef struct packed {
    mode_e              mode;
    logic               done;
    logic [XY_W-1:0]    org_x;
    logic [XY_W-1:0]    org_y;
    logic [COLOR_W-1:0] color;
    row_t               col;
    row_t               row;
    logic [SPAN_W-1:0]  span;
  } step_t;

endpackage

>>> sv/crsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsr_front
// Takes load and advance words, runs the midpoint trackers, emits step records.
// ----------------------------------------------------------------------------
module crsr_front #(
  parameter int COORD_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  crsr_pkg::in_t   in_data_i,
  output logic           push_o,
  output crsr_pkg::step_t step_o
);
  import crsr_pkg::*;

  localparam int CW = COORD_BITS;

  logic              active_q, ring_q;
  logic [CW-1:0]     ox_q, oy_q;
  logic [COLOR_W-1:0] color_q;
  row_t              col_q, orow_q, odrow_q, irow_q, idrow_q;
  err_t              oerr_q, ierr_q;
  logic [SPAN_W-1:0] span_q;

  // step results
  logic              oge, ige, ifrz, iupd, done;
  row_t              orow_n, odrow_n, irow_n, idrow_n, col_n;
  err_t              oerr_n, ierr_n, odrow_x, idrow_x, col_x;
  logic [SPAN_W-1:0] span_n;

  // load values
  row_t              r_s, th_s, ri_s;

  always_comb begin
    col_x   = ERR_W'(col_q);

    oge     = ~oerr_q[ERR_W-1];
    orow_n  = oge ? orow_q - ROW_W'(1) : orow_q;
    odrow_n = oge ? odrow_q + ROW_W'(2) : odrow_q;
    odrow_x = ERR_W'(odrow_n);
    oerr_n  = oerr_q + (oge ? odrow_x : '0) + (col_x <<< 1) + ERR_W'(3);

    // inner circle stays below the column for good once it drops there
    ifrz    = irow_q < col_q;
    iupd    = ring_q && !ifrz;
    ige     = ~ierr_q[ERR_W-1];
    irow_n  = (iupd && ige) ? irow_q - ROW_W'(1) : irow_q;
    idrow_n = (iupd && ige) ? idrow_q + ROW_W'(2) : idrow_q;
    idrow_x = ERR_W'(idrow_n);
    ierr_n  = iupd ? ierr_q + (ige ? idrow_x : '0) + (col_x <<< 1) + ERR_W'(3) : ierr_q;

    if (irow_n < col_q) begin
      span_n = SPAN_W'(orow_n) - SPAN_W'(col_q) + SPAN_W'(1);
    end else begin
      span_n = SPAN_W'(orow_n) - SPAN_W'(irow_n);
    end

    col_n = col_q + ROW_W'(1);
    done  = col_n > orow_n;

    r_s  = ROW_W'(in_data_i.radius);
    th_s = ROW_W'(in_data_i.thickness);
    ri_s = r_s - th_s;
  end

  always_comb begin
    push_o        = in_fire_i && (in_data_i.operation == OP_ADVANCE);
    step_o.mode   = !active_q ? MODE_IDLE : (ring_q ? MODE_RING : MODE_FILL);
    step_o.done   = done;
    step_o.org_x  = XY_W'(ox_q);
    step_o.org_y  = XY_W'(oy_q);
    step_o.color  = color_q;
    step_o.col    = col_q;
    step_o.row    = orow_q;
    step_o.span   = span_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ring_q   <= 1'b0;
      ox_q     <= '0;
      oy_q     <= '0;
      color_q  <= '0;
      col_q    <= '0;
      orow_q   <= '0;
      odrow_q  <= '0;
      oerr_q   <= '0;
      irow_q   <= '0;
      idrow_q  <= '0;
      ierr_q   <= '0;
      span_q   <= '0;
    end else if (in_fire_i) begin
      if (in_data_i.operation == OP_LOAD) begin
        active_q <= 1'b1;
        ring_q   <= in_data_i.thickness < in_data_i.radius;
        ox_q     <= in_data_i.center_x[CW-1:0];
        oy_q     <= in_data_i.center_y[CW-1:0];
        color_q  <= in_data_i.paint_color;
        col_q    <= '0;
        orow_q   <= r_s;
        odrow_q  <= ROW_W'(0) - (r_s <<< 1);
        oerr_q   <= ERR_W'(1) - ERR_W'(r_s);
        irow_q   <= ri_s;
        idrow_q  <= ROW_W'(0) - (ri_s <<< 1);
        ierr_q   <= ERR_W'(1) - ERR_W'(ri_s);
        span_q   <= SPAN_W'(in_data_i.thickness);
      end else if (active_q) begin
        active_q <= !done;
        col_q    <= col_n;
        orow_q   <= orow_n;
        odrow_q  <= odrow_n;
        oerr_q   <= oerr_n;
        irow_q   <= irow_n;
        idrow_q  <= idrow_n;
        ierr_q   <= ierr_n;
        if (ring_q) begin
          span_q <= span_n;
        end
      end
    end
  end

endmodule

>>> sv/crsr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsr_queue
// Short queue of step records between the front and the back.
// ----------------------------------------------------------------------------
module crsr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  crsr_pkg::step_t data_i,
  input  logic            pop_i,
  output crsr_pkg::step_t data_o,
  output logic            valid_o,
  output logic            full_o
);
  import crsr_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  step_t            slots_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign data_o  = slots_q[rd_ptr_q];
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CNT_W'(QDEPTH);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/crsr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsr_back
// Expands a step record into spans or idle ack, one word per cycle when ready.
// ----------------------------------------------------------------------------
module crsr_back #(
  parameter int COORD_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crsr_pkg::step_t head_i,
  input  logic            head_valid_i,
  output logic            pop_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output crsr_pkg::out_t  out_data_o
);
  import crsr_pkg::*;

  localparam int CW = COORD_BITS;

  logic             out_valid_q;
  out_t             out_q, out_d;
  logic [IDX_W-1:0] idx_q, idx_last;
  logic             can_load, fire, at_last;

  logic [CW-1:0]    xp, xn, yp, yn, yt, xo, yo, px, py;
  logic [LEN_W-1:0] len_t, len_2x, len_2y, w, h;

  always_comb begin
    xp     = CW'(head_i.col);
    xn     = CW'(0) - xp;
    yp     = CW'(head_i.row);
    yn     = CW'(0) - yp;
    yt     = yp - CW'(head_i.span) + CW'(1);
    len_t  = head_i.span[LEN_W-1:0];
    len_2x = LEN_W'({head_i.col, 1'b0});
    len_2y = LEN_W'({head_i.row, 1'b0});

    case (head_i.mode)
      MODE_RING: idx_last = IDX_W'(NSPAN_RING - 1);
      MODE_FILL: idx_last = IDX_W'(NSPAN_FILL - 1);
      default:   idx_last = '0;
    endcase

    xo = xp;
    yo = yp;
    w  = LEN_W'(1);
    h  = LEN_W'(1);
    if (head_i.mode == MODE_RING) begin
      case (idx_q)
        3'd0:    begin xo = xn; yo = yn; h = len_t; end
        3'd1:    begin xo = xp; yo = yn; h = len_t; end
        3'd2:    begin xo = yt; yo = xn; w = len_t; end
        3'd3:    begin xo = yt; yo = xp; w = len_t; end
        3'd4:    begin xo = xp; yo = yt; h = len_t; end
        3'd5:    begin xo = xn; yo = yt; h = len_t; end
        3'd6:    begin xo = yn; yo = xp; w = len_t; end
        default: begin xo = yn; yo = xn; w = len_t; end
      endcase
    end else begin
      case (idx_q)
        3'd0:    begin xo = xp; yo = yn; h = len_2y; end
        3'd1:    begin xo = xn; yo = yn; h = len_2y; end
        3'd2:    begin xo = yp; yo = xn; h = len_2x; end
        default: begin xo = yn; yo = xn; h = len_2x; end
      endcase
    end

    px = CW'(head_i.org_x) + xo;
    py = CW'(head_i.org_y) + yo;

    at_last = idx_q == idx_last;
    out_d.last     = at_last;
    if (head_i.mode == MODE_IDLE) begin
      out_d.kind       = KIND_IDLE;
      out_d.rect_x     = '0;
      out_d.rect_y     = '0;
      out_d.rect_w     = '0;
      out_d.rect_h     = '0;
      out_d.rect_color = '0;
      out_d.finished   = 1'b0;
    end else begin
      out_d.kind       = KIND_SPAN;
      out_d.rect_x     = XY_W'(px);
      out_d.rect_y     = XY_W'(py);
      out_d.rect_w     = w;
      out_d.rect_h     = h;
      out_d.rect_color = head_i.color;
      out_d.finished   = head_i.done;
    end
  end

  assign can_load    = !out_valid_q || out_ready_i;
  assign fire        = can_load && head_valid_i;
  assign pop_o       = fire && at_last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_last ? '0 : idx_q + IDX_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> sv/circle_ring_span_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_ring_span_rasterizer
// Midpoint circle span generator for filled discs and rings.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o  | load or advance command
//  out     | output    | out_valid_o/out_ready_i| one span or idle ack
//
//  a load returns no word; an advance returns 4 words on a filled disc, 8 on
//  a ring and 1 idle ack when no circle is running
//  the output port gives one word per cycle while out_ready_i is high, and
//  the front accepts a new word every cycle as long as the two-entry step
//  queue has room
//  reset clears all tracker state and the queue at once, no clearing pass
//  out_ready_i low holds the output register; the queue fills, then
//  in_ready_o drops
//
module circle_ring_span_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  crsr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output crsr_pkg::out_t out_data_o
);
  import crsr_pkg::*;

  // front to queue
  logic  in_fire, push;
  step_t push_step;

  // queue to back
  step_t head;
  logic  q_valid, q_full, pop;

  // the front never blocks on the output side, only on queue space
  assign in_ready_o = !q_full;
  assign in_fire    = in_valid_i && in_ready_o;

  // trackers: outer circle, inner circle and current ring gap
  crsr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .push_o    (push),
    .step_o    (push_step)
  );

  // decouples step computation from span output
  crsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_step),
    .pop_i   (pop),
    .data_o  (head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // span sequencer with registered output
  crsr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_valid),
    .pop_o        (pop),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  // no step record dropped on a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("step pushed into full queue");

  // back only retires a record that is there
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // idle ack is a single closing word of no finished circle
  a_idle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_IDLE) |->
      (out_data_o.last && !out_data_o.finished))
    else $error("malformed idle ack");

  // spans of one step leave without gaps
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last) |=> out_valid_o)
    else $error("bubble inside a step");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circle ring span rasterizer. A directed table
// covers the idle ack, the zero radius disc, coordinate wrap, the largest
// filled disc and ring, and replacing a running circle. A random run of
// mostly well-formed load/advance sequences follows, with stall bursts on
// both channels and one long output hold-off. Every span is compared with an
// in-bench midpoint tracker.
// ----------------------------------------------------------------------------
module testbench;
  import crsr_pkg::*;

  localparam int RANDOM_WORDS = 336;
  localparam int CALM_WORDS   = 60;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    in_t  word;
    bit   pinned;  // first result typed in below
    out_t first;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic calm     = 1'b0;
  logic hold_off = 1'b0;

  int   words_sent   = 0;
  int   loads_sent   = 0;
  int   words_seen   = 0;
  int   span_errors  = 0;
  int   circles_done = 0;
  int   cycle_count  = 0;
  int   stall_left   = 0;

  // expected spans and idle acks, oldest first
  out_t pending_spans[$];
  plan_row_t plan[$];

  // circle tracker
  logic        trk_active = 1'b0;
  logic        trk_ring   = 1'b0;
  logic [15:0] org_x      = '0;
  logic [15:0] org_y      = '0;
  logic [15:0] trk_color  = '0;
  logic [15:0] gap_len    = '0;
  int col, col_step, out_row, out_err, out_drow, in_row, in_err, in_drow;

  circle_ring_span_rasterizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_spans.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] wrap16(input logic [15:0] base, input int off);
    logic [15:0] o;
    o = off[15:0];
    return base + o;
  endfunction

  function automatic void add_span(input logic [15:0] x, input logic [15:0] y,
                                   input int w, input int h);
    out_t s;
    s.kind       = KIND_SPAN;
    s.rect_x     = x;
    s.rect_y     = y;
    s.rect_w     = w[12:0];
    s.rect_h     = h[12:0];
    s.rect_color = trk_color;
    s.last       = 1'b0;
    s.finished   = 1'b0;
    pending_spans.push_back(s);
  endfunction

  // one midpoint step of a tracker circle
  function automatic void midpoint_step(inout int row, inout int err, inout int drow);
    if (err >= 0) begin
      row  = row - 1;
      drow = drow + 2;
      err  = err + drow;
    end
    err = err + col_step + 1;
  endfunction

  // works out the words one command causes and queues them, returns the count
  function automatic int rasterize_word(input in_t w);
    int r, th, ri, x, y, t, n, tmp, k;
    out_t ack;
    logic finishing;
    if (w.operation == OP_LOAD) begin
      r  = int'(w.radius);
      th = int'(w.thickness);
      ri = r - th;
      org_x     = w.center_x;
      org_y     = w.center_y;
      trk_color = w.paint_color;
      trk_ring  = th < r;
      col       = 0;
      col_step  = 2;
      out_err   = 1 - r;
      out_drow  = -2 * r;
      out_row   = r;
      in_err    = 1 - ri;
      in_drow   = -2 * ri;
      in_row    = ri;
      gap_len   = th[15:0];
      trk_active = 1'b1;
      return 0;
    end
    if (!trk_active) begin
      ack      = '0;
      ack.kind = KIND_IDLE;
      ack.last = 1'b1;
      pending_spans.push_back(ack);
      return 1;
    end
    x = col;
    y = out_row;
    if (trk_ring) begin
      t = int'(gap_len);
      add_span(wrap16(org_x, -x), wrap16(org_y, -y), 1, t);
      add_span(wrap16(org_x, x), wrap16(org_y, -y), 1, t);
      add_span(wrap16(org_x, y - t + 1), wrap16(org_y, -x), t, 1);
      add_span(wrap16(org_x, y - t + 1), wrap16(org_y, x), t, 1);
      add_span(wrap16(org_x, x), wrap16(org_y, y - t + 1), 1, t);
      add_span(wrap16(org_x, -x), wrap16(org_y, y - t + 1), 1, t);
      add_span(wrap16(org_x, -y), wrap16(org_y, x), t, 1);
      add_span(wrap16(org_x, -y), wrap16(org_y, -x), t, 1);
      n = 8;
      midpoint_step(in_row, in_err, in_drow);
      midpoint_step(out_row, out_err, out_drow);
      // past the inner circle the gap runs out to the diagonal
      if (in_row < col) tmp = out_row - col + 1;
      else tmp = out_row - in_row;
      gap_len = tmp[15:0];
    end else begin
      add_span(wrap16(org_x, x), wrap16(org_y, -y), 1, y + y);
      add_span(wrap16(org_x, -x), wrap16(org_y, -y), 1, y + y);
      add_span(wrap16(org_x, y), wrap16(org_y, -x), 1, x + x);
      add_span(wrap16(org_x, -y), wrap16(org_y, -x), 1, x + x);
      n = 4;
      midpoint_step(out_row, out_err, out_drow);
    end
    col       = col + 1;
    col_step  = col_step + 2;
    finishing = col > out_row;
    if (finishing) begin
      trk_active = 1'b0;
      circles_done++;
    end
    for (k = pending_spans.size() - n; k < pending_spans.size(); k++) begin
      pending_spans[k].finished = finishing;
    end
    pending_spans[pending_spans.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic in_t load_word(input logic [15:0] cx, input logic [15:0] cy,
                                    input logic [11:0] r, input logic [11:0] th,
                                    input logic [15:0] c);
    in_t w;
    w.operation   = OP_LOAD;
    w.center_x    = cx;
    w.center_y    = cy;
    w.radius      = r;
    w.thickness   = th;
    w.paint_color = c;
    return w;
  endfunction

  function automatic out_t span_word(input logic [15:0] x, input logic [15:0] y,
                                     input logic [12:0] w, input logic [12:0] h,
                                     input logic [15:0] c, input logic fin);
    out_t s;
    s.kind       = KIND_SPAN;
    s.rect_x     = x;
    s.rect_y     = y;
    s.rect_w     = w;
    s.rect_h     = h;
    s.rect_color = c;
    s.last       = 1'b0;
    s.finished   = fin;
    return s;
  endfunction

  task automatic add_row(input in_t w, input bit pinned = 1'b0, input out_t first = '0);
    plan_row_t row;
    row.word   = w;
    row.pinned = pinned;
    row.first  = first;
    plan.push_back(row);
  endtask

  // mostly well-formed: load, then advances until the circle ends, with
  // occasional replacing loads and idle advances; advance payloads are noise
  function automatic in_t random_word();
    in_t w;
    int pick, r, th;
    w.center_x    = 16'($urandom);
    w.center_y    = 16'($urandom);
    w.radius      = 12'($urandom);
    w.thickness   = 12'($urandom);
    w.paint_color = 16'($urandom);
    w.operation   = OP_ADVANCE;
    pick = $urandom_range(0, 99);
    if (trk_active ? (pick < 8) : (pick < 88)) begin
      w.operation = OP_LOAD;
      pick = $urandom_range(0, 99);
      if (pick < 60) r = $urandom_range(0, 10);
      else if (pick < 90) r = $urandom_range(11, 40);
      else r = $urandom_range(41, 4095);
      w.radius = r[11:0];
      pick = $urandom_range(0, 99);
      if (pick < 50 && r > 0) begin
        th = $urandom_range(0, r - 1);
        w.thickness = th[11:0];
      end else if (pick < 85) begin
        th = r + $urandom_range(0, 3);
        if (th > 4095) th = 4095;
        w.thickness = th[11:0];
      end
    end
    return w;
  endfunction

  task automatic send_word(input in_t w);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
    if (w.operation == OP_LOAD) loads_sent++;
  endtask

  task automatic note_miss(input string why, input out_t want, input out_t got);
    if (span_errors < 10) begin
      $display("%s at cycle %0d", why, cycle_count);
      $display("  expected kind %0d x %h y %h w %0d h %0d color %h last %0d fin %0d",
               want.kind, want.rect_x, want.rect_y, want.rect_w, want.rect_h,
               want.rect_color, want.last, want.finished);
      $display("  actual   kind %0d x %h y %h w %0d h %0d color %h last %0d fin %0d",
               got.kind, got.rect_x, got.rect_y, got.rect_w, got.rect_h,
               got.rect_color, got.last, got.finished);
    end
    span_errors++;
  endtask

  // output side: check every accepted word, then pick next cycle's ready
  always @(posedge clk_i) begin : output_side
    out_t got, want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        words_seen++;
        if (pending_spans.size() == 0) begin
          note_miss("word with nothing expected", '0, got);
        end else begin
          want = pending_spans.pop_front();
          if (got.kind !== want.kind || got.rect_x !== want.rect_x ||
              got.rect_y !== want.rect_y || got.rect_w !== want.rect_w ||
              got.rect_h !== want.rect_h || got.rect_color !== want.rect_color ||
              got.last !== want.last || got.finished !== want.finished) begin
            note_miss("span mismatch", want, got);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (hold_off) begin
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one long output hold-off mid-run so the step queue fills and input stalls
  initial begin : long_hold
    wait (words_sent >= 140);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    int k, n;
    in_t w, adv;

    adv = '0;
    adv.operation = OP_ADVANCE;

    // advance straight after reset gives an idle ack
    add_row(adv, 1'b1, '{kind: KIND_IDLE, last: 1'b1, default: '0});
    // zero radius: one step of zero-height spans, circle done at once
    add_row(load_word(16'h0000, 16'h0000, 12'd0, 12'd0, 16'hFFFF));
    add_row(adv, 1'b1, span_word(16'h0000, 16'h0000, 13'd1, 13'd0, 16'hFFFF, 1'b1));
    add_row(adv, 1'b1, '{kind: KIND_IDLE, last: 1'b1, default: '0});
    // small ring at the top corner, spans wrap around zero
    add_row(load_word(16'hFFFF, 16'hFFFF, 12'd5, 12'd2, 16'hA5A5));
    add_row(adv);
    add_row(adv);
    add_row(adv);
    // largest filled disc replaces the running ring
    add_row(load_word(16'h0000, 16'h0000, 12'd4095, 12'd4095, 16'h0000));
    add_row(adv, 1'b1, span_word(16'h0000, 16'hF001, 13'd1, 13'd8190, 16'h0000, 1'b0));
    add_row(adv);
    // largest ring, thinnest wall
    add_row(load_word(16'h8000, 16'h1234, 12'd4095, 12'd1, 16'h5A5A));
    add_row(adv, 1'b1, span_word(16'h8000, 16'h0235, 13'd1, 13'd1, 16'h5A5A, 1'b0));
    add_row(adv);
    // largest ring, inner radius one
    add_row(load_word(16'h7FFF, 16'h0000, 12'd4095, 12'd4094, 16'h1234));
    add_row(adv);
    add_row(adv);
    // zero thickness ring of radius one
    add_row(load_word(16'd100, 16'd200, 12'd1, 12'd0, 16'h00FF));
    add_row(adv);
    add_row(adv);
    // thickness equal to radius fills: three steps, then idle
    add_row(load_word(16'd50, 16'd60, 12'd3, 12'd3, 16'hFFFF));
    add_row(adv);
    add_row(adv);
    add_row(adv);
    add_row(adv, 1'b1, '{kind: KIND_IDLE, last: 1'b1, default: '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < plan.size(); k++) begin
      n = rasterize_word(plan[k].word);
      if (plan[k].pinned) pending_spans[pending_spans.size() - n] = plan[k].first;
      send_word(plan[k].word);
    end

    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS - CALM_WORDS) calm <= 1'b1;
      w = random_word();
      n = rasterize_word(w);
      send_word(w);
    end
    in_valid <= 1'b0;

    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    span_errors += pending_spans.size();

    $display("covered %0d commands (%0d loads), %0d output words, %0d circles run to the end",
             words_sent, loads_sent, words_seen, circles_done);
    $display("with random stalls on both sides and one long output hold-off");
    if (span_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad words", span_errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> circle_ring_span_rasterizer.f
sv/crsr_pkg.sv
sv/crsr_front.sv
sv/crsr_queue.sv
sv/crsr_back.sv
sv/circle_ring_span_rasterizer.sv
sim/testbench.sv
